// File: src/rtt_pkg.sv
`default_nettype none
package rtt_pkg;
    localparam int SLOTS_DEF = 16;
    localparam int MAX_PAYLOAD_DEF = 1024;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_SEND = 2'd1,
        OP_TICK = 2'd2,
        OP_ACK  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_ADDED     = 4'd0,
        ST_TOO_LARGE = 4'd1,
        ST_FULL      = 4'd2,
        ST_SEND      = 4'd3,
        ST_NONE      = 4'd4,
        ST_EXPIRED   = 4'd5,
        ST_TICK_DONE = 4'd6,
        ST_ACK_HIT   = 4'd7,
        ST_ACK_MISS  = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        SL_FREE  = 2'd0,
        SL_READY = 2'd1,
        SL_WAIT  = 2'd2
    } slot_state_t;

    // entry record held by a cell, travels along the ring
    typedef struct packed {
        logic        occ;
        slot_state_t st;
        logic [5:0]  slot;
        logic [31:0] id;
        logic [31:0] addr;
        logic [15:0] port;
        logic [7:0]  sends;
        logic [7:0]  limit;
        logic [15:0] tmo;
        logic [15:0] wait_cnt;
    } entry_t;

    // command held during a pass and checked against the head entry at each step
    typedef struct packed {
        op_t         op;
        logic [31:0] id;
        logic        done;   // first hit already taken in this pass
    } cmd_t;
endpackage
`default_nettype wire

// File: src/retransmit_tracking_table.sv
`default_nettype none
// Channel | Direction | Signals
// in      | input     | in_valid, in_stall, operation .. timeout_ticks
// out     | output    | out_valid, out_stall, status .. last
// Entries sit in a chain of SLOTS cells, oldest first, packed from cell 0 up (N held).
// An add loads cell N in its accept cycle; its word is valid on the next cycle.
// A poll, tick or ack takes the accept cycle, N steps that each put the head entry back
// behind the live entries or drop it, and a closing cycle that gives the word with last set.
// A step or the closing cycle waits while the output register holds a stalled word;
// the input stalls until the pass is over and the output register can take a word.
// Reset empties the table at once.
module retransmit_tracking_table #(
    parameter int SLOTS       = rtt_pkg::SLOTS_DEF,
    parameter int MAX_PAYLOAD = rtt_pkg::MAX_PAYLOAD_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [1:0]  operation,
    input  wire  [31:0] packet_id,
    input  wire  [15:0] packet_size,
    input  wire  [31:0] dest_address,
    input  wire  [15:0] dest_port,
    input  wire  [7:0]  max_sends,
    input  wire  [15:0] timeout_ticks,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [3:0]  status,
    output logic [3:0]  slot,
    output logic [31:0] out_packet_id,
    output logic [31:0] out_address,
    output logic [15:0] out_port,
    output logic [7:0]  sends_done,
    output logic        last
);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = $clog2(SLOTS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PASS = 4'b0010,
        S_FIN  = 4'b0100,
        S_ADD  = 4'b1000
    } fsm_t;

    fsm_t                 state_reg, state_next;
    rtt_pkg::cmd_t        cmd_reg, cmd_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        num_reg, num_next;
    logic [SLOTS-1:0]     used_reg, used_next;
    logic                 ov_reg, ov_next;
    logic [3:0]           os_reg, os_next;
    rtt_pkg::entry_t      oe_reg, oe_next;
    logic                 ol_reg, ol_next;

    rtt_pkg::entry_t      cells [SLOTS];
    rtt_pkg::entry_t      head_mod;
    logic                 shift;
    logic                 load_en;
    logic [CW-1:0]        load_idx;
    rtt_pkg::entry_t      load_entry;

    // packed chain: a kept head entry goes back in right behind the live entries
    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            rtt_pkg::entry_t prev;
            if (g == SLOTS - 1)
            begin : g_tail
                assign prev = '0;
            end
            else
            begin : g_mid
                assign prev = cells[g+1];
            end
            rtt_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift      (shift),
                .load       (load_en && (load_idx == CW'(g))),
                .load_entry (load_entry),
                .prev_entry (prev),
                .entry      (cells[g])
            );
        end
    endgenerate

    logic  out_free;
    assign out_free = !ov_reg || !out_stall;

    logic [SLOTS-1:0] free_vec;
    logic [5:0]       free_slot;
    logic             any_free;
    always_comb
    begin
        free_vec  = ~used_reg;
        free_slot = '0;
        any_free  = 1'b0;
        for (int k = SLOTS - 1; k >= 0; k--)
            if (free_vec[k])
            begin
                free_slot = 6'(k);
                any_free  = 1'b1;
            end
    end

    always_comb
    begin
        logic emit_hit;
        logic drop;
        emit_hit   = 1'b0;
        drop       = 1'b0;
        state_next = state_reg;
        cmd_next   = cmd_reg;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        used_next  = used_reg;
        ov_next    = ov_reg && out_stall;
        os_next    = os_reg;
        oe_next    = oe_reg;
        ol_next    = ol_reg;
        shift      = 1'b0;
        load_en    = 1'b0;
        load_idx   = num_reg - 1'b1;
        load_entry = '0;
        head_mod   = cells[0];
        in_stall   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = !out_free;
                if (in_valid && out_free)
                begin
                    cmd_next.op   = rtt_pkg::op_t'(operation);
                    cmd_next.id   = packet_id;
                    cmd_next.done = 1'b0;
                    cnt_next      = num_reg;
                    if (rtt_pkg::op_t'(operation) == rtt_pkg::OP_ADD)
                    begin
                        if (32'(packet_size) > 32'(MAX_PAYLOAD))
                        begin
                            ov_next = 1'b1; os_next = rtt_pkg::ST_TOO_LARGE;
                            oe_next = '0;   ol_next = 1'b1;
                        end
                        else if (!any_free)
                        begin
                            ov_next = 1'b1; os_next = rtt_pkg::ST_FULL;
                            oe_next = '0;   ol_next = 1'b1;
                        end
                        else
                        begin
                            load_entry.occ      = 1'b1;
                            load_entry.st       = rtt_pkg::SL_READY;
                            load_entry.slot     = free_slot;
                            load_entry.id       = packet_id;
                            load_entry.addr     = dest_address;
                            load_entry.port     = dest_port;
                            load_entry.sends    = '0;
                            load_entry.limit    = max_sends;
                            load_entry.tmo      = timeout_ticks;
                            load_entry.wait_cnt = '0;
                            load_en  = 1'b1;
                            load_idx = num_reg;
                            num_next = num_reg + 1'b1;
                            used_next[free_slot[SW-1:0]] = 1'b1;
                            ov_next = 1'b1; os_next = rtt_pkg::ST_ADDED;
                            oe_next = load_entry; ol_next = 1'b1;
                        end
                    end
                    else if (num_reg == '0)
                        state_next = S_FIN;
                    else
                        state_next = S_PASS;
                end
            end
            S_PASS:
            begin
                if (out_free)
                begin
                    shift = 1'b1;
                    if (cells[0].occ)
                    begin
                        unique case (cmd_reg.op)
                            rtt_pkg::OP_SEND:
                                if (!cmd_reg.done && cells[0].st == rtt_pkg::SL_READY)
                                begin
                                    if (head_mod.sends != 8'hFF)
                                        head_mod.sends = head_mod.sends + 1'b1;
                                    head_mod.st = rtt_pkg::SL_WAIT;
                                    emit_hit = 1'b1;
                                    os_next  = rtt_pkg::ST_SEND;
                                end
                            rtt_pkg::OP_TICK:
                                if (cells[0].st == rtt_pkg::SL_WAIT)
                                begin
                                    if (head_mod.wait_cnt != 16'hFFFF)
                                        head_mod.wait_cnt = head_mod.wait_cnt + 1'b1;
                                    if (head_mod.wait_cnt >= head_mod.tmo)
                                    begin
                                        if (head_mod.sends < head_mod.limit)
                                        begin
                                            head_mod.wait_cnt = '0;
                                            head_mod.st = rtt_pkg::SL_READY;
                                        end
                                        else
                                        begin
                                            drop = 1'b1;
                                            ov_next = 1'b1;
                                            os_next = rtt_pkg::ST_EXPIRED;
                                            oe_next = head_mod;
                                            ol_next = 1'b0;
                                        end
                                    end
                                end
                            rtt_pkg::OP_ACK:
                                if (!cmd_reg.done && cells[0].st == rtt_pkg::SL_WAIT &&
                                    cells[0].id == cmd_reg.id)
                                begin
                                    drop     = 1'b1;
                                    emit_hit = 1'b1;
                                    os_next  = rtt_pkg::ST_ACK_HIT;
                                end
                            default: ;
                        endcase
                    end
                    // hit word is held back and given at the end with last set
                    if (emit_hit)
                    begin
                        cmd_next.done = 1'b1;
                        oe_next = head_mod;
                    end
                    if (drop)
                    begin
                        num_next = num_reg - 1'b1;
                        used_next[cells[0].slot[SW-1:0]] = 1'b0;
                    end
                    else
                    begin
                        load_en    = 1'b1;
                        load_entry = head_mod;
                    end
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                        state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    oe_next = '0;
                    unique case (cmd_reg.op)
                        rtt_pkg::OP_SEND:
                        begin
                            os_next = cmd_reg.done ? rtt_pkg::ST_SEND : rtt_pkg::ST_NONE;
                            oe_next = cmd_reg.done ? oe_reg : '0;
                        end
                        rtt_pkg::OP_ACK:
                        begin
                            os_next = cmd_reg.done ? rtt_pkg::ST_ACK_HIT : rtt_pkg::ST_ACK_MISS;
                            oe_next = cmd_reg.done ? oe_reg : '0;
                        end
                        default: os_next = rtt_pkg::ST_TICK_DONE;
                    endcase
                    ol_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            num_reg   <= '0;
            used_reg  <= '0;
            ov_reg    <= 1'b0;
            cmd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            num_reg   <= num_next;
            used_reg  <= used_next;
            ov_reg    <= ov_next;
            cmd_reg   <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        os_reg  <= os_next;
        oe_reg  <= oe_next;
        ol_reg  <= ol_next;
    end

    assign out_valid     = ov_reg;
    assign status        = os_reg;
    assign slot          = oe_reg.slot[3:0];
    assign out_packet_id = oe_reg.id;
    assign out_address   = oe_reg.addr;
    assign out_port      = oe_reg.port;
    assign sends_done    = oe_reg.sends;
    assign last          = ol_reg;
endmodule
`default_nettype wire

// File: src/rtt_cell.sv
`default_nettype none
// One chain cell: holds an entry, takes its upper neighbor's entry on a shift,
// or a given entry on a load.
module rtt_cell (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  shift,
    input  wire                  load,
    input  rtt_pkg::entry_t      load_entry,
    input  rtt_pkg::entry_t      prev_entry,
    output rtt_pkg::entry_t      entry
);
    rtt_pkg::entry_t entry_reg;
    rtt_pkg::entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (load)
            entry_next = load_entry;
        else if (shift)
            entry_next = prev_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '0;
        else
            entry_reg <= entry_next;
    end

    assign entry = entry_reg;
endmodule
`default_nettype wire
